// ----- rtl/convex_hull_gift_wrap_macros.svh -----
// Assertion macros for the hull block
`ifndef CONVEX_HULL_GIFT_WRAP_MACROS_SVH
`define CONVEX_HULL_GIFT_WRAP_MACROS_SVH
`ifndef SYNTHESIS
`define CHG_ASSERT_IMPL(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define CHG_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define CHG_ASSERT_IMPL(label, clk, rst_n, a, c)
`define CHG_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// ----- rtl/chg_pkg.sv -----
// ----------------------------------------------------------------------------
// chg_pkg
// Types and constants for the gift-wrap convex hull block.
// ----------------------------------------------------------------------------
package chg_pkg;
	localparam int MAX_POINTS_DEF  = 64;
	localparam int COORD_WIDTH_DEF = 16;
	localparam int CW = COORD_WIDTH_DEF;

	typedef struct packed {
		logic signed [CW-1:0] point_x;
		logic signed [CW-1:0] point_y;
		logic                 last_point;
	} in_item_t;

	typedef struct packed {
		logic signed [CW-1:0] hull_x;
		logic signed [CW-1:0] hull_y;
		logic                 hull_last;
		logic                 hull_overflow;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_LOAD, ST_MIN, ST_SCAN, ST_CMP1, ST_CMP2, ST_DECIDE, ST_EMIT
	} state_t;

	// Control sent from the sequencer into the cell row
	typedef struct packed {
		logic load;   // shift a new point in
		logic rot;    // rotate row by one cell
	} row_ctl_t;
endpackage

// ----- rtl/convex_hull_gift_wrap.sv -----
// ----------------------------------------------------------------------------
// convex_hull_gift_wrap
// Jarvis march over points held in a rotating row of cells.
// Load: one point per cycle. For n stored points the walk first finds the start
// vertex, then scans the row once per hull vertex, closing scan included
// (row step, registered products, then cross and lengths decided).
// Vertices emit one per cycle from an output register. Reset clears control.
// The receiver cannot stall; busy is high from the last point to the end.
// ----------------------------------------------------------------------------
`include "convex_hull_gift_wrap_macros.svh"
module convex_hull_gift_wrap #(
	parameter int MAX_POINTS  = chg_pkg::MAX_POINTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  chg_pkg::in_item_t  in_item,
	output logic               strobe,
	output chg_pkg::out_item_t out_item
);
	localparam int N  = MAX_POINTS;
	localparam int W  = chg_pkg::CW;
	localparam int CB = $clog2(N+1);
	localparam int IB = $clog2(N);
	localparam int DW = W + 1;
	localparam int PW = 2*DW + 1;

	chg_pkg::state_t st_q, st_d;
	logic [CB-1:0] cnt_q, idx_q, hcnt_q, ecnt_q;
	logic [2*W-1:0] head, din;
	chg_pkg::row_ctl_t ctl;
	logic signed [W-1:0] sx_q, sy_q, px_q, py_q, cx_q, cy_q;
	logic signed [W-1:0] hx, hy;
	logic ovf_q, closed_q;
	logic signed [W-1:0] hbx [N];
	logic signed [W-1:0] hby [N];
	logic signed [DW-1:0] ax, ay, bx, by;
	logic signed [PW-1:0] m1_s1, m2_s1, m3_s1, m4_s1, m5_s1, m6_s1;
	logic signed [PW+1:0] cr, la, lb;
	logic signed [W-1:0] qx_q, qy_q;
	logic take;
	logic accept;

	assign accept = start && !busy;
	assign din = {in_item.point_x[W-1:0], in_item.point_y[W-1:0]};
	assign hx = $signed(head[2*W-1:W]);
	assign hy = $signed(head[W-1:0]);

	chg_row #(.N(N), .W(W)) u_row (.clk(clk), .ctl(ctl), .count(cnt_q), .din(din),
		.head(head));

	// difference vectors and products, registered once then summed
	assign ax = DW'(cx_q) - DW'(px_q);
	assign ay = DW'(cy_q) - DW'(py_q);
	assign bx = DW'(qx_q) - DW'(px_q);
	assign by = DW'(qy_q) - DW'(py_q);

	always_ff @(posedge clk) begin
		m1_s1 <= PW'(ax) * PW'(by);
		m2_s1 <= PW'(ay) * PW'(bx);
		m3_s1 <= PW'(ax) * PW'(ax);
		m4_s1 <= PW'(ay) * PW'(ay);
		m5_s1 <= PW'(bx) * PW'(bx);
		m6_s1 <= PW'(by) * PW'(by);
	end

	assign cr = (PW+2)'(m1_s1) - (PW+2)'(m2_s1);
	assign la = (PW+2)'(m3_s1) + (PW+2)'(m4_s1);
	assign lb = (PW+2)'(m5_s1) + (PW+2)'(m6_s1);

	assign take = (cr < 0) || (cr == 0 && lb > la);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			chg_pkg::ST_LOAD:   if (accept && in_item.last_point) st_d = chg_pkg::ST_MIN;
			chg_pkg::ST_MIN:    if (idx_q == cnt_q) st_d = chg_pkg::ST_SCAN;
			chg_pkg::ST_SCAN:   st_d = (idx_q >= cnt_q) ? chg_pkg::ST_DECIDE : chg_pkg::ST_CMP1;
			chg_pkg::ST_CMP1:   st_d = chg_pkg::ST_CMP2;
			chg_pkg::ST_CMP2:   st_d = chg_pkg::ST_SCAN;
			chg_pkg::ST_DECIDE: if (closed_q || (cx_q == sx_q && cy_q == sy_q) ||
				hcnt_q == CB'(N)) st_d = chg_pkg::ST_EMIT;
				else st_d = chg_pkg::ST_SCAN;
			chg_pkg::ST_EMIT:   if (ecnt_q + 1'b1 == hcnt_q) st_d = chg_pkg::ST_LOAD;
			default:            st_d = chg_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		ctl = '0;
		unique case (st_q)
			chg_pkg::ST_LOAD: ctl.load = accept && cnt_q < CB'(N);
			chg_pkg::ST_MIN:  ctl.rot = idx_q < cnt_q;
			chg_pkg::ST_SCAN: ctl.rot = idx_q < cnt_q;
			default: ctl = '0;
		endcase
	end

	assign busy = st_q != chg_pkg::ST_LOAD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= chg_pkg::ST_LOAD;
			cnt_q <= '0;
			idx_q <= '0;
			hcnt_q <= '0;
			ecnt_q <= '0;
			ovf_q <= 1'b0;
			closed_q <= 1'b0;
			strobe <= 1'b0;
		end else begin
			st_q <= st_d;
			strobe <= 1'b0;
			unique case (st_q)
				chg_pkg::ST_LOAD: begin
					if (ctl.load) cnt_q <= cnt_q + 1'b1;
					idx_q <= '0;
					ovf_q <= 1'b0;
					closed_q <= 1'b0;
				end
				chg_pkg::ST_MIN: begin
					if (idx_q < cnt_q) idx_q <= idx_q + 1'b1;
					else begin
						idx_q <= '0;
						px_q <= sx_q; py_q <= sy_q;
						hbx[0] <= sx_q; hby[0] <= sy_q;
						hcnt_q <= CB'(1);
					end
				end
				chg_pkg::ST_SCAN: begin
					if (idx_q < cnt_q) idx_q <= idx_q + 1'b1;
				end
				chg_pkg::ST_DECIDE: begin
					idx_q <= '0;
					ecnt_q <= '0;
					if (!(cx_q == sx_q && cy_q == sy_q)) begin
						if (hcnt_q == CB'(N)) ovf_q <= 1'b1;
						else begin
							hbx[hcnt_q[IB-1:0]] <= cx_q;
							hby[hcnt_q[IB-1:0]] <= cy_q;
							hcnt_q <= hcnt_q + 1'b1;
							px_q <= cx_q; py_q <= cy_q;
						end
					end
				end
				chg_pkg::ST_EMIT: begin
					strobe <= 1'b1;
					out_item.hull_x <= hbx[ecnt_q[IB-1:0]];
					out_item.hull_y <= hby[ecnt_q[IB-1:0]];
					out_item.hull_last <= ecnt_q + 1'b1 == hcnt_q;
					out_item.hull_overflow <= ovf_q;
					ecnt_q <= ecnt_q + 1'b1;
					if (ecnt_q + 1'b1 == hcnt_q) cnt_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// payload: min tracking, candidate capture
	always_ff @(posedge clk) begin
		if (st_q == chg_pkg::ST_MIN && idx_q < cnt_q) begin
			if (idx_q == '0 || sx_q > hx || (sx_q == hx && sy_q > hy)) begin
				sx_q <= hx; sy_q <= hy;
			end
		end
		if (st_q == chg_pkg::ST_SCAN && idx_q < cnt_q) begin
			qx_q <= hx; qy_q <= hy;
			if (idx_q == '0) begin
				cx_q <= hx; cy_q <= hy;
			end
		end
		if (st_q == chg_pkg::ST_CMP2 && idx_q != CB'(1) && take) begin
			cx_q <= qx_q; cy_q <= qy_q;
		end
	end

	`CHG_ASSERT_IMPL(a_cnt, clk, arst_n, 1'b1, cnt_q <= CB'(N))
	`CHG_ASSERT_NEXT(a_busy, clk, arst_n, accept && in_item.last_point, busy)
	`CHG_ASSERT_IMPL(a_strb, clk, arst_n, strobe, busy || out_item.hull_last)
endmodule

// ----- rtl/chg_cell.sv -----
// ----------------------------------------------------------------------------
// chg_cell
// One storage cell of the point row; passes its point to the neighbor.
// ----------------------------------------------------------------------------
module chg_cell #(
	parameter int W = chg_pkg::COORD_WIDTH_DEF
) (
	input  logic                  clk,
	input  chg_pkg::row_ctl_t     ctl,
	input  logic [2*W-1:0]        load_d,
	input  logic [2*W-1:0]        rot_d,
	output logic [2*W-1:0]        pt
);
	logic [2*W-1:0] pt_q;
	always_ff @(posedge clk) begin
		if (ctl.load) pt_q <= load_d;
		else if (ctl.rot) pt_q <= rot_d;
	end
	assign pt = pt_q;
endmodule

// ----- rtl/chg_row.sv -----
// ----------------------------------------------------------------------------
// chg_row
// Chain of point cells. Load shifts in at cell 0; rotate circulates the row
// so cell 0 presents each stored point in turn.
// ----------------------------------------------------------------------------
module chg_row #(
	parameter int N = chg_pkg::MAX_POINTS_DEF,
	parameter int W = chg_pkg::COORD_WIDTH_DEF
) (
	input  logic              clk,
	input  chg_pkg::row_ctl_t ctl,
	input  logic [$clog2(N+1)-1:0] count,
	input  logic [2*W-1:0]    din,
	output logic [2*W-1:0]    head
);
	logic [2*W-1:0] p [N];
	// load shifts toward higher cells; rotate moves cell i+1 into i and the
	// head back into the last filled cell
	for (genvar i = 0; i < N; i++) begin : g_c
		logic [2*W-1:0] ld, rd;
		if (i == 0) assign ld = din;
		else assign ld = p[i-1];
		if (i == N-1) assign rd = head;
		else assign rd = (count == ($clog2(N+1))'(i+1)) ? head : p[i+1];
		chg_cell #(.W(W)) u_c (.clk(clk), .ctl(ctl), .load_d(ld), .rot_d(rd), .pt(p[i]));
	end
	assign head = p[0];
endmodule
